[rtl/core/tgc_pkg.sv]
// ----------------------------------------------------------------------------
// tgc_pkg
// Shared widths, codes and types of the touch gesture classifier.
// ----------------------------------------------------------------------------
package tgc_pkg;

  // field widths
  localparam int COORD_BITS     = 12;
  localparam int TIME_BITS      = 32;
  localparam int CMD_BITS       = 3;
  localparam int DIST_BITS      = 12;
  localparam int DRAG_BITS      = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  // decoupling queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = 1;
  localparam int QCOUNT_BITS = 2;

  // start point collection
  localparam int COUNT_BITS    = 2;
  localparam int COLLECT_SLOTS = 2;

  // raw command codes
  localparam logic [CMD_BITS-1:0] CMD_PRESS = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_LIFT  = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_POS_X = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_POS_Y = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_ACK   = 3'd4;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CLICK_DIST = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SWIPE_DIST = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DRAG_MS    = 2'd2;

  // register reset values
  localparam logic [DIST_BITS-1:0] CLICK_DIST_RESET = 12'd20;
  localparam logic [DIST_BITS-1:0] SWIPE_DIST_RESET = 12'd50;
  localparam logic [DRAG_BITS-1:0] DRAG_MS_RESET    = 16'd500;

  // decoded operation
  typedef enum logic [2:0] {
    OP_PRESS = 3'd0,
    OP_LIFT  = 3'd1,
    OP_POS_X = 3'd2,
    OP_POS_Y = 3'd3,
    OP_ACK   = 3'd4,
    OP_OTHER = 3'd5
  } op_t;

  // reported phase
  typedef enum logic [2:0] {
    PHASE_IDLE     = 3'd0,
    PHASE_COLLECT  = 3'd1,
    PHASE_PRESSED  = 3'd2,
    PHASE_DRAGGING = 3'd3,
    PHASE_CLICKED  = 3'd4,
    PHASE_SWIPED   = 3'd5
  } phase_code_t;

  // reported gesture
  typedef enum logic [2:0] {
    GEST_NONE  = 3'd0,
    GEST_CLICK = 3'd1,
    GEST_UP    = 3'd2,
    GEST_DOWN  = 3'd3,
    GEST_LEFT  = 3'd4,
    GEST_RIGHT = 3'd5
  } gesture_t;

  // queue entry
  typedef struct packed {
    op_t                  op;
    logic [COORD_BITS-1:0] coord;
    logic [TIME_BITS-1:0]  time_ms;
  } op_entry_t;

  // register write beat
  typedef struct packed {
    logic                      write;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;
  } cfg_beat_t;

endpackage

[rtl/core/tgc_if.sv]
// ----------------------------------------------------------------------------
// tgc_if
// Event and status channels of the touch gesture classifier.
// ----------------------------------------------------------------------------
interface tgc_evt_if;
  logic                            valid;
  logic                            ready;
  logic [tgc_pkg::CMD_BITS-1:0]    command;
  logic [tgc_pkg::COORD_BITS-1:0]  coord;
  logic [tgc_pkg::TIME_BITS-1:0]   time_ms;

  modport source (output valid, output command, output coord, output time_ms, input ready);
  modport sink   (input valid, input command, input coord, input time_ms, output ready);
endinterface

interface tgc_res_if;
  logic                            valid;
  logic                            ready;
  logic [2:0]                      phase;
  logic [2:0]                      gesture;
  logic                            gesture_pending;
  logic [tgc_pkg::COORD_BITS-1:0]  start_x;
  logic [tgc_pkg::COORD_BITS-1:0]  start_y;
  logic [tgc_pkg::COORD_BITS-1:0]  current_x;
  logic [tgc_pkg::COORD_BITS-1:0]  current_y;

  modport source (output valid, output phase, output gesture, output gesture_pending,
                  output start_x, output start_y, output current_x, output current_y,
                  input ready);
  modport sink   (input valid, input phase, input gesture, input gesture_pending,
                  input start_x, input start_y, input current_x, input current_y,
                  output ready);
endinterface

[rtl/core/tgc_front.sv]
// ----------------------------------------------------------------------------
// tgc_front
// Accepts event beats, decodes the command and queues the operation.
// ----------------------------------------------------------------------------
module tgc_front (
  input  logic                 clk,
  input  logic                 rst,
  tgc_evt_if.sink              evt,
  output tgc_pkg::op_entry_t   head,
  output logic                 head_valid,
  input  logic                 pop
);

  tgc_pkg::op_entry_t                   entry_in;
  tgc_pkg::op_entry_t                   queue_mem [tgc_pkg::QUEUE_DEPTH];
  logic [tgc_pkg::QPTR_BITS-1:0]        wr_ptr;
  logic [tgc_pkg::QPTR_BITS-1:0]        rd_ptr;
  logic [tgc_pkg::QCOUNT_BITS-1:0]      count;
  logic                                 push;

  // command decode
  always_comb begin
    entry_in.coord   = evt.coord;
    entry_in.time_ms = evt.time_ms;
    case (evt.command)
      tgc_pkg::CMD_PRESS: entry_in.op = tgc_pkg::OP_PRESS;
      tgc_pkg::CMD_LIFT:  entry_in.op = tgc_pkg::OP_LIFT;
      tgc_pkg::CMD_POS_X: entry_in.op = tgc_pkg::OP_POS_X;
      tgc_pkg::CMD_POS_Y: entry_in.op = tgc_pkg::OP_POS_Y;
      tgc_pkg::CMD_ACK:   entry_in.op = tgc_pkg::OP_ACK;
      default:            entry_in.op = tgc_pkg::OP_OTHER;
    endcase
  end

  // handshake
  assign evt.ready  = (count < tgc_pkg::QCOUNT_BITS'(tgc_pkg::QUEUE_DEPTH));
  assign push       = evt.valid && evt.ready;
  assign head_valid = (count != '0);
  assign head       = queue_mem[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      queue_mem[wr_ptr] <= entry_in;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/core/tgc_back.sv]
// ----------------------------------------------------------------------------
// tgc_back
// Runs queued operations through the touch state machine; the state
// registers double as the status output register.
// ----------------------------------------------------------------------------
module tgc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  tgc_pkg::cfg_beat_t   cfg,
  input  tgc_pkg::op_entry_t   head,
  input  logic                 head_valid,
  output logic                 pop,
  tgc_res_if.source            res
);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_COLLECT  = 6'b000010,
    ST_PRESSED  = 6'b000100,
    ST_DRAGGING = 6'b001000,
    ST_CLICKED  = 6'b010000,
    ST_SWIPED   = 6'b100000
  } state_t;

  function automatic logic [tgc_pkg::COORD_BITS-1:0] absdiff(
    input logic [tgc_pkg::COORD_BITS-1:0] a,
    input logic [tgc_pkg::COORD_BITS-1:0] b
  );
    absdiff = (a > b) ? (a - b) : (b - a);
  endfunction

  // configuration registers
  logic [tgc_pkg::DIST_BITS-1:0]  click_distance;
  logic [tgc_pkg::DIST_BITS-1:0]  swipe_distance;
  logic [tgc_pkg::DRAG_BITS-1:0]  drag_interval_ms;

  // touch state
  state_t                          state, state_next;
  logic [tgc_pkg::COUNT_BITS-1:0]  collect_count, collect_count_next;
  logic [tgc_pkg::COORD_BITS-1:0]  press_x, press_x_next;
  logic [tgc_pkg::COORD_BITS-1:0]  press_y, press_y_next;
  logic [tgc_pkg::COORD_BITS-1:0]  track_x, track_x_next;
  logic [tgc_pkg::COORD_BITS-1:0]  track_y, track_y_next;
  logic [tgc_pkg::TIME_BITS-1:0]   press_time, press_time_next;
  tgc_pkg::gesture_t               gesture, gesture_next;
  logic                            pending, pending_next;
  logic                            out_valid;

  // lift path: tracked point after copy-back, deltas
  logic [tgc_pkg::COORD_BITS-1:0]  lift_x, lift_y;
  logic [tgc_pkg::COORD_BITS-1:0]  dx, dy;
  logic [tgc_pkg::TIME_BITS-1:0]   elapsed;
  logic                            copy_back;

  assign pop = head_valid && (!out_valid || res.ready);

  assign copy_back = (state == ST_PRESSED) && ((track_x == '0) || (track_y == '0));
  assign lift_x    = copy_back ? press_x : track_x;
  assign lift_y    = copy_back ? press_y : track_y;
  assign dx        = absdiff(lift_x, press_x);
  assign dy        = absdiff(lift_y, press_y);
  assign elapsed   = head.time_ms - press_time;

  // next state for the operation at the queue head
  always_comb begin
    state_next         = state;
    collect_count_next = collect_count;
    press_x_next       = press_x;
    press_y_next       = press_y;
    track_x_next       = track_x;
    track_y_next       = track_y;
    press_time_next    = press_time;
    gesture_next       = gesture;
    pending_next       = pending;
    case (state)
      ST_IDLE: begin
        if (head.op == tgc_pkg::OP_PRESS) begin
          press_x_next       = '0;
          press_y_next       = '0;
          track_x_next       = '0;
          track_y_next       = '0;
          press_time_next    = '0;
          collect_count_next = '0;
          state_next         = ST_COLLECT;
        end
      end
      ST_COLLECT: begin
        if (head.op == tgc_pkg::OP_POS_X) begin
          press_x_next    = head.coord;
          press_time_next = head.time_ms;
        end else if (head.op == tgc_pkg::OP_POS_Y) begin
          press_y_next    = head.coord;
          press_time_next = head.time_ms;
        end
        collect_count_next = collect_count + 1'b1;
        if ((press_x_next != '0) && (press_y_next != '0)) begin
          track_x_next       = press_x_next;
          track_y_next       = press_y_next;
          collect_count_next = '0;
          state_next         = ST_PRESSED;
        end else if (collect_count_next >=
                     tgc_pkg::COUNT_BITS'(tgc_pkg::COLLECT_SLOTS)) begin
          collect_count_next = '0;
          state_next         = ST_IDLE;
        end
      end
      ST_PRESSED, ST_DRAGGING: begin
        if ((head.op == tgc_pkg::OP_POS_X) || (head.op == tgc_pkg::OP_POS_Y)) begin
          if (head.op == tgc_pkg::OP_POS_X) begin
            track_x_next = head.coord;
          end else begin
            track_y_next = head.coord;
          end
          if ((state == ST_PRESSED) && (track_x_next != '0) && (track_y_next != '0) &&
              (elapsed > tgc_pkg::TIME_BITS'(drag_interval_ms))) begin
            state_next = ST_DRAGGING;
          end
        end else if (head.op == tgc_pkg::OP_LIFT) begin
          track_x_next = lift_x;
          track_y_next = lift_y;
          if ((dx < click_distance) && (dy < click_distance)) begin
            state_next   = ST_CLICKED;
            gesture_next = tgc_pkg::GEST_CLICK;
            pending_next = 1'b1;
          end else if ((dx < dy) && (dy > swipe_distance)) begin
            state_next   = ST_SWIPED;
            gesture_next = (lift_y > press_y) ? tgc_pkg::GEST_DOWN : tgc_pkg::GEST_UP;
            pending_next = 1'b1;
          end else if (!(dx < dy) && (dx > swipe_distance)) begin
            state_next   = ST_SWIPED;
            gesture_next = (lift_x > press_x) ? tgc_pkg::GEST_RIGHT : tgc_pkg::GEST_LEFT;
            pending_next = 1'b1;
          end else begin
            state_next   = ST_IDLE;
            gesture_next = tgc_pkg::GEST_NONE;
            pending_next = 1'b0;
          end
        end
      end
      ST_CLICKED, ST_SWIPED: begin
        if (head.op == tgc_pkg::OP_ACK) begin
          press_x_next       = '0;
          press_y_next       = '0;
          track_x_next       = '0;
          track_y_next       = '0;
          press_time_next    = '0;
          collect_count_next = '0;
          gesture_next       = tgc_pkg::GEST_NONE;
          pending_next       = 1'b0;
          state_next         = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      click_distance   <= tgc_pkg::CLICK_DIST_RESET;
      swipe_distance   <= tgc_pkg::SWIPE_DIST_RESET;
      drag_interval_ms <= tgc_pkg::DRAG_MS_RESET;
    end else if (cfg.write) begin
      case (cfg.index)
        tgc_pkg::CFG_CLICK_DIST: click_distance   <= cfg.data[tgc_pkg::DIST_BITS-1:0];
        tgc_pkg::CFG_SWIPE_DIST: swipe_distance   <= cfg.data[tgc_pkg::DIST_BITS-1:0];
        tgc_pkg::CFG_DRAG_MS:    drag_interval_ms <= cfg.data[tgc_pkg::DRAG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // state update, one operation per popped beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      collect_count <= '0;
      press_x       <= '0;
      press_y       <= '0;
      track_x       <= '0;
      track_y       <= '0;
      press_time    <= '0;
      gesture       <= tgc_pkg::GEST_NONE;
      pending       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (pop) begin
        state         <= state_next;
        collect_count <= collect_count_next;
        press_x       <= press_x_next;
        press_y       <= press_y_next;
        track_x       <= track_x_next;
        track_y       <= track_y_next;
        press_time    <= press_time_next;
        gesture       <= gesture_next;
        pending       <= pending_next;
        out_valid     <= 1'b1;
      end else if (res.ready) begin
        out_valid     <= 1'b0;
      end
    end
  end

  // status beat
  always_comb begin
    case (state)
      ST_IDLE:     res.phase = tgc_pkg::PHASE_IDLE;
      ST_COLLECT:  res.phase = tgc_pkg::PHASE_COLLECT;
      ST_PRESSED:  res.phase = tgc_pkg::PHASE_PRESSED;
      ST_DRAGGING: res.phase = tgc_pkg::PHASE_DRAGGING;
      ST_CLICKED:  res.phase = tgc_pkg::PHASE_CLICKED;
      ST_SWIPED:   res.phase = tgc_pkg::PHASE_SWIPED;
      default:     res.phase = tgc_pkg::PHASE_IDLE;
    endcase
  end

  assign res.valid           = out_valid;
  assign res.gesture         = gesture;
  assign res.gesture_pending = pending;
  assign res.start_x         = press_x;
  assign res.start_y         = press_y;
  assign res.current_x       = track_x;
  assign res.current_y       = track_y;

endmodule

[rtl/core/touch_gesture_classifier.sv]
// ----------------------------------------------------------------------------
// touch_gesture_classifier
// Touch event gesture classifier: decode front, two-entry queue, state back.
// ----------------------------------------------------------------------------
// path: an accepted event beat is written into the decode queue; once popped, its result is
//   loaded into the touch state registers, which drive the status beat
// throughput: one event per cycle while the queue has room; the back end takes one queued event per cycle
//   whenever the status register is empty or being drained
// reset: synchronous, clears queue, touch state and status valid, loads default registers
module touch_gesture_classifier (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [tgc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [tgc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  tgc_evt_if.sink                              evt,
  tgc_res_if.source                            res
);

  tgc_pkg::cfg_beat_t  cfg;
  tgc_pkg::op_entry_t  head;
  logic                head_valid;
  logic                pop;

  // register write beat
  assign cfg.write = cfg_write;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // decode and queue
  tgc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .evt        (evt),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  // touch state machine
  tgc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .res        (res)
  );

endmodule

[rtl/core/tgc_checker.sv]
// ----------------------------------------------------------------------------
// tgc_checker
// Port-level checks on the status channel of the gesture classifier.
// ----------------------------------------------------------------------------
module tgc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            res_valid,
  input logic                            res_ready,
  input logic [2:0]                      phase,
  input logic [2:0]                      gesture,
  input logic                            gesture_pending,
  input logic [tgc_pkg::COORD_BITS-1:0]  start_x,
  input logic [tgc_pkg::COORD_BITS-1:0]  start_y
);

  // stalled status beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(phase) && $stable(gesture) &&
    $stable(gesture_pending) && $stable(start_x) && $stable(start_y))
    else $error("status beat changed while stalled");

  // pending flag tracks the gesture phases
  a_pending: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (gesture_pending ==
      ((phase == tgc_pkg::PHASE_CLICKED) || (phase == tgc_pkg::PHASE_SWIPED))))
    else $error("pending flag disagrees with phase");

  // no gesture outside the gesture phases
  a_no_gesture: assert property (@(posedge clk) disable iff (rst)
    res_valid && ((phase == tgc_pkg::PHASE_IDLE) || (phase == tgc_pkg::PHASE_COLLECT) ||
    (phase == tgc_pkg::PHASE_PRESSED) || (phase == tgc_pkg::PHASE_DRAGGING))
    |-> (gesture == tgc_pkg::GEST_NONE))
    else $error("gesture reported outside a gesture phase");

  // a click phase reports a click
  a_click: assert property (@(posedge clk) disable iff (rst)
    res_valid && (phase == tgc_pkg::PHASE_CLICKED) |-> (gesture == tgc_pkg::GEST_CLICK))
    else $error("clicked phase without click gesture");

  // a held touch has a full start point
  a_start: assert property (@(posedge clk) disable iff (rst)
    res_valid && ((phase == tgc_pkg::PHASE_PRESSED) || (phase == tgc_pkg::PHASE_DRAGGING))
    |-> (start_x != '0) && (start_y != '0))
    else $error("touch held without a start point");

endmodule

bind touch_gesture_classifier tgc_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .phase           (res.phase),
  .gesture         (res.gesture),
  .gesture_pending (res.gesture_pending),
  .start_x         (res.start_x),
  .start_y         (res.start_y)
);

[tb/sv/touch_gesture_classifier_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// touch_gesture_classifier_tb
// Self-checking bench for the touch gesture classifier. A short table of
// hand-written events runs first, then random touch sequences under several
// register settings. A cycle-level predictor of the touch state machine
// builds the expected status beat for every accepted event, and each status
// beat is compared field by field in order. Both channels idle at random,
// with two long status hold-offs and drain pauses on the event side.
// ----------------------------------------------------------------------------
module touch_gesture_classifier_tb;
  import tgc_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 150;
  localparam int SETTLE       = 6;
  localparam int PHASE_ITEMS  = 255;
  localparam int NUM_SETTINGS = 6;
  localparam int MAX_PRINTS   = 60;

  // spare command codes the block decodes as other operations
  localparam logic [CMD_BITS-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_BITS-1:0] CMD_SPARE_HI = 3'd7;

  typedef enum {SINK_OPEN, SINK_MOSTLY, SINK_PATTERN, SINK_SPARSE} sink_mode_t;

  typedef struct packed {
    phase_code_t           phase;
    gesture_t              gesture;
    logic                  pending;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] current_x;
    logic [COORD_BITS-1:0] current_y;
  } status_t;

  typedef struct {
    logic [CMD_BITS-1:0]   cmd;
    logic [COORD_BITS-1:0] coord;
    logic [TIME_BITS-1:0]  t;
    bit                    pinned;
    status_t               want;
  } event_row_t;

  typedef struct {
    bit      pinned;
    status_t want;
  } pin_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  tgc_evt_if evt_bus ();
  tgc_res_if res_bus ();

  touch_gesture_classifier dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .evt       (evt_bus),
    .res       (res_bus)
  );

  // predicted touch state and register copies
  phase_code_t            touch_phase;
  logic [COUNT_BITS-1:0]  slots_used;
  logic [COORD_BITS-1:0]  st_x, st_y, cur_x, cur_y;
  logic [TIME_BITS-1:0]   press_ms;
  gesture_t               held_gesture;
  logic                   gesture_wait;
  logic [DIST_BITS-1:0]   click_lim;
  logic [DIST_BITS-1:0]   swipe_lim;
  logic [DRAG_BITS-1:0]   drag_ms;

  status_t    status_q[$];
  pin_t       pin_q[$];
  event_row_t event_table[$];

  int errors;
  int events_sent;
  int beats_seen;
  int cycle_count;
  int burst_left;
  int settings_run;
  int drag_entries;
  int holds_done;
  int gesture_tally[6];
  bit hold_req;
  logic [TIME_BITS-1:0] now_ms;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d status beats outstanding",
               cycle_count, status_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got_v,
                        input logic [31:0] want_v);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("mismatch at status beat %0d: %s got 0x%0h expected 0x%0h",
               beats_seen, what, got_v, want_v);
  endtask

  task automatic check_status(input status_t got, input status_t want);
    if (got.phase !== want.phase) report("phase", got.phase, want.phase);
    if (got.gesture !== want.gesture) report("gesture", got.gesture, want.gesture);
    if (got.pending !== want.pending) report("gesture_pending", got.pending, want.pending);
    if (got.start_x !== want.start_x) report("start_x", got.start_x, want.start_x);
    if (got.start_y !== want.start_y) report("start_y", got.start_y, want.start_y);
    if (got.current_x !== want.current_x) report("current_x", got.current_x, want.current_x);
    if (got.current_y !== want.current_y) report("current_y", got.current_y, want.current_y);
  endtask

  function automatic status_t st(input phase_code_t ph, input gesture_t g, input logic pend,
                                 input int sx, input int sy, input int cx, input int cy);
    status_t s;
    s.phase     = ph;
    s.gesture   = g;
    s.pending   = pend;
    s.start_x   = sx[COORD_BITS-1:0];
    s.start_y   = sy[COORD_BITS-1:0];
    s.current_x = cx[COORD_BITS-1:0];
    s.current_y = cy[COORD_BITS-1:0];
    return s;
  endfunction

  function automatic void clear_touch();
    st_x       = '0;
    st_y       = '0;
    cur_x      = '0;
    cur_y      = '0;
    press_ms   = '0;
    slots_used = '0;
  endfunction

  // next status of the touch state machine for one event
  function automatic status_t advance_touch(input logic [CMD_BITS-1:0] cmd,
                                            input logic [COORD_BITS-1:0] c,
                                            input logic [TIME_BITS-1:0] t);
    logic [COORD_BITS-1:0] dx, dy;
    gesture_t g;
    case (touch_phase)
      PHASE_IDLE: begin
        if (cmd == CMD_PRESS) begin
          clear_touch();
          touch_phase = PHASE_COLLECT;
        end
      end
      PHASE_COLLECT: begin
        // every event takes a slot, only positions store a value
        if (cmd == CMD_POS_X) begin
          st_x     = c;
          press_ms = t;
        end else if (cmd == CMD_POS_Y) begin
          st_y     = c;
          press_ms = t;
        end
        slots_used = slots_used + 1'b1;
        if (st_x != 0 && st_y != 0) begin
          cur_x       = st_x;
          cur_y       = st_y;
          slots_used  = '0;
          touch_phase = PHASE_PRESSED;
        end else if (slots_used >= COLLECT_SLOTS) begin
          slots_used  = '0;
          touch_phase = PHASE_IDLE;
        end
      end
      PHASE_PRESSED, PHASE_DRAGGING: begin
        if (cmd == CMD_POS_X || cmd == CMD_POS_Y) begin
          if (cmd == CMD_POS_X) cur_x = c;
          else cur_y = c;
          // drag once held past the interval, time wraps
          if (touch_phase == PHASE_PRESSED && cur_x != 0 && cur_y != 0 &&
              (t - press_ms) > {{(TIME_BITS-DRAG_BITS){1'b0}}, drag_ms}) begin
            touch_phase = PHASE_DRAGGING;
            drag_entries++;
          end
        end else if (cmd == CMD_LIFT) begin
          // unset tracked coordinate falls back to the start point
          if (touch_phase == PHASE_PRESSED && (cur_x == 0 || cur_y == 0)) begin
            cur_x = st_x;
            cur_y = st_y;
          end
          dx = (cur_x > st_x) ? cur_x - st_x : st_x - cur_x;
          dy = (cur_y > st_y) ? cur_y - st_y : st_y - cur_y;
          g  = GEST_NONE;
          if (dx < click_lim && dy < click_lim) begin
            g = GEST_CLICK;
          end else if (dx < dy) begin
            if (dy > swipe_lim) g = (cur_y > st_y) ? GEST_DOWN : GEST_UP;
          end else if (dx > swipe_lim) begin
            g = (cur_x > st_x) ? GEST_RIGHT : GEST_LEFT;
          end
          held_gesture = g;
          gesture_wait = (g != GEST_NONE);
          if (g == GEST_NONE) touch_phase = PHASE_IDLE;
          else if (g == GEST_CLICK) touch_phase = PHASE_CLICKED;
          else touch_phase = PHASE_SWIPED;
          gesture_tally[int'(g)]++;
        end
      end
      PHASE_CLICKED, PHASE_SWIPED: begin
        if (cmd == CMD_ACK) begin
          clear_touch();
          held_gesture = GEST_NONE;
          gesture_wait = 1'b0;
          touch_phase  = PHASE_IDLE;
        end
      end
      default: touch_phase = PHASE_IDLE;
    endcase
    return st(touch_phase, held_gesture, gesture_wait, st_x, st_y, cur_x, cur_y);
  endfunction

  // beat monitor: compare status beats, predict on event beats
  always @(posedge clk) begin : beat_monitor
    status_t got;
    status_t pred;
    pin_t    p;
    if (!rst) begin
      if (res_bus.valid && res_bus.ready) begin
        beats_seen++;
        got.phase     = phase_code_t'(res_bus.phase);
        got.gesture   = gesture_t'(res_bus.gesture);
        got.pending   = res_bus.gesture_pending;
        got.start_x   = res_bus.start_x;
        got.start_y   = res_bus.start_y;
        got.current_x = res_bus.current_x;
        got.current_y = res_bus.current_y;
        if (status_q.size() == 0) report("status beat with nothing expected", 0, 0);
        else check_status(got, status_q.pop_front());
      end
      if (evt_bus.valid && evt_bus.ready) begin
        pred = advance_touch(evt_bus.command, evt_bus.coord, evt_bus.time_ms);
        p    = pin_q.pop_front();
        status_q.push_back(p.pinned ? p.want : pred);
      end
    end
  end

  // status sink: random stall modes plus the long hold-off on request
  initial begin : status_sink
    sink_mode_t mode;
    int mode_left;
    int k;
    logic [7:0] pattern;
    mode_left = 0;
    k = 0;
    mode = SINK_OPEN;
    pattern = 8'hFF;
    res_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        res_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        holds_done++;
      end else begin
        if (mode_left == 0) begin
          mode      = sink_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(10, 80);
          pattern   = $urandom_range(1, 255);
        end
        mode_left--;
        k++;
        case (mode)
          SINK_OPEN:    res_bus.ready <= 1'b1;
          SINK_MOSTLY:  res_bus.ready <= ($urandom_range(0, 3) != 0);
          SINK_PATTERN: res_bus.ready <= pattern[k % 8];
          default:      res_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // offer one event beat, bursts separated by random gaps
  task automatic send_ev(input logic [CMD_BITS-1:0] cmd, input logic [COORD_BITS-1:0] c,
                         input logic [TIME_BITS-1:0] t, input bit pinned = 1'b0,
                         input status_t want = '0);
    int gap;
    pin_t p;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        evt_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    p.pinned = pinned;
    p.want   = want;
    pin_q.push_back(p);
    evt_bus.valid   <= 1'b1;
    evt_bus.command <= cmd;
    evt_bus.coord   <= c;
    evt_bus.time_ms <= t;
    @(posedge clk);
    while (!evt_bus.ready) @(posedge clk);
    events_sent++;
  endtask

  // stop offering until every status beat is back
  task automatic drain_status();
    evt_bus.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_CLICK_DIST: click_lim = data[DIST_BITS-1:0];
      CFG_SWIPE_DIST: swipe_lim = data[DIST_BITS-1:0];
      CFG_DRAG_MS:    drag_ms   = data[DRAG_BITS-1:0];
      default: ;
    endcase
  endtask

  // timestamps: mostly small steps, some near the drag interval, some jumps
  function automatic logic [TIME_BITS-1:0] tick();
    case ($urandom_range(0, 9))
      0:       now_ms = $urandom;
      1, 2, 3: now_ms = now_ms + $urandom_range(0, int'(drag_ms) * 2 + 2);
      4:       now_ms = now_ms + drag_ms + $urandom_range(0, 1);
      default: now_ms = now_ms + $urandom_range(0, 40);
    endcase
    return now_ms;
  endfunction

  function automatic logic [COORD_BITS-1:0] pick_start();
    if ($urandom_range(0, 9) == 0) return '0;
    return $urandom_range(1, 4095);
  endfunction

  // move around a start point: distances near the thresholds, some large jumps, some zeros
  function automatic logic [COORD_BITS-1:0] near_coord(input logic [COORD_BITS-1:0] base);
    int mag;
    int v;
    if ($urandom_range(0, 19) == 0) return '0;
    case ($urandom_range(0, 3))
      0:       mag = $urandom_range(0, int'(click_lim) + 1);
      1:       mag = int'(swipe_lim) + int'($urandom_range(0, 2)) - 1;
      2:       mag = $urandom_range(0, 4095);
      default: mag = $urandom_range(0, 8);
    endcase
    v = ($urandom_range(0, 1) == 1) ? int'(base) + mag : int'(base) - mag;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[COORD_BITS-1:0];
  endfunction

  // one touch: press, start point, moves, lift, acknowledge
  task automatic play_touch();
    logic [COORD_BITS-1:0] sx, sy;
    int moves;
    sx = pick_start();
    sy = pick_start();
    send_ev(CMD_PRESS, $urandom_range(0, 4095), tick());
    // sometimes spoil a collection slot
    if ($urandom_range(0, 9) == 0)
      send_ev($urandom_range(0, int'(CMD_SPARE_HI)), $urandom_range(0, 4095), tick());
    if ($urandom_range(0, 1) == 1) begin
      send_ev(CMD_POS_X, sx, tick());
      send_ev(CMD_POS_Y, sy, tick());
    end else begin
      send_ev(CMD_POS_Y, sy, tick());
      send_ev(CMD_POS_X, sx, tick());
    end
    moves = $urandom_range(0, 6);
    repeat (moves) begin
      if ($urandom_range(0, 1) == 1) send_ev(CMD_POS_X, near_coord(sx), tick());
      else send_ev(CMD_POS_Y, near_coord(sy), tick());
    end
    send_ev(CMD_LIFT, $urandom_range(0, 4095), tick());
    if ($urandom_range(0, 7) == 0)
      send_ev($urandom_range(0, int'(CMD_SPARE_HI)), $urandom_range(0, 4095), tick());
    if ($urandom_range(0, 9) != 0) send_ev(CMD_ACK, $urandom_range(0, 4095), tick());
  endtask

  // random traffic for one register setting
  task automatic run_random(input int n_items, input bit long_hold);
    int stop_at;
    int hold_at;
    int pause_at;
    bit held;
    bit paused;
    stop_at  = events_sent + n_items;
    hold_at  = events_sent + n_items / 4;
    pause_at = events_sent + (3 * n_items) / 4;
    held     = !long_hold;
    paused   = 1'b0;
    while (events_sent < stop_at) begin
      if (!held && events_sent >= hold_at) begin
        hold_req = 1'b1;
        held = 1'b1;
      end
      if (!paused && events_sent >= pause_at) begin
        drain_status();
        paused = 1'b1;
      end
      if ($urandom_range(0, 99) < 80) play_touch();
      else send_ev($urandom_range(0, int'(CMD_SPARE_HI)), $urandom_range(0, 4095), $urandom);
    end
  endtask

  task automatic row(input logic [CMD_BITS-1:0] cmd, input int c, input logic [31:0] t,
                     input bit pinned = 1'b0, input status_t want = '0);
    event_row_t r;
    r.cmd    = cmd;
    r.coord  = c[COORD_BITS-1:0];
    r.t      = t;
    r.pinned = pinned;
    r.want   = want;
    event_table.push_back(r);
  endtask

  initial begin : stimulus
    int ph;
    logic [DIST_BITS-1:0] click_set[NUM_SETTINGS];
    logic [DIST_BITS-1:0] swipe_set[NUM_SETTINGS];
    logic [DRAG_BITS-1:0] drag_set[NUM_SETTINGS];

    rst             <= 1'b1;
    cfg_write       <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    evt_bus.valid   <= 1'b0;
    evt_bus.command <= '0;
    evt_bus.coord   <= '0;
    evt_bus.time_ms <= '0;
    hold_req     = 1'b0;
    errors       = 0;
    events_sent  = 0;
    beats_seen   = 0;
    cycle_count  = 0;
    burst_left   = 0;
    drag_entries = 0;
    holds_done   = 0;
    settings_run = 1;
    now_ms       = '0;
    foreach (gesture_tally[i]) gesture_tally[i] = 0;

    // predictor reset state
    touch_phase  = PHASE_IDLE;
    held_gesture = GEST_NONE;
    gesture_wait = 1'b0;
    clear_touch();
    click_lim = CLICK_DIST_RESET;
    swipe_lim = SWIPE_DIST_RESET;
    drag_ms   = DRAG_MS_RESET;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed events at the reset register values
    row(CMD_SPARE_LO, 0, 32'd0, 1, st(PHASE_IDLE, GEST_NONE, 0, 0, 0, 0, 0));
    row(CMD_ACK, 4095, 32'hFFFF_FFFF, 1, st(PHASE_IDLE, GEST_NONE, 0, 0, 0, 0, 0));
    row(CMD_LIFT, 0, 32'd0, 1, st(PHASE_IDLE, GEST_NONE, 0, 0, 0, 0, 0));
    row(CMD_POS_X, 4095, 32'd0, 1, st(PHASE_IDLE, GEST_NONE, 0, 0, 0, 0, 0));
    row(CMD_PRESS, 0, 32'd0, 1, st(PHASE_COLLECT, GEST_NONE, 0, 0, 0, 0, 0));
    row(CMD_POS_X, 4095, 32'd10, 1, st(PHASE_COLLECT, GEST_NONE, 0, 4095, 0, 0, 0));
    row(CMD_POS_Y, 4095, 32'd20, 1,
        st(PHASE_PRESSED, GEST_NONE, 0, 4095, 4095, 4095, 4095));
    row(CMD_PRESS, 1, 32'd30);
    row(CMD_LIFT, 0, 32'd40, 1, st(PHASE_CLICKED, GEST_CLICK, 1, 4095, 4095, 4095, 4095));
    row(CMD_LIFT, 0, 32'd50);
    row(CMD_ACK, 0, 32'd60, 1, st(PHASE_IDLE, GEST_NONE, 0, 0, 0, 0, 0));
    // spare command and a zero coordinate use up both slots
    row(CMD_PRESS, 0, 32'd70);
    row(CMD_SPARE_HI, 4095, 32'd80);
    row(CMD_POS_X, 0, 32'd90);
    // press time at the top of the range, drag across the wrap
    row(CMD_PRESS, 0, 32'd100);
    row(CMD_POS_X, 1, 32'hFFFF_FFF0);
    row(CMD_POS_Y, 1, 32'hFFFF_FFFF);
    row(CMD_POS_Y, 200, 32'd500);
    row(CMD_LIFT, 0, 32'd600);
    row(CMD_ACK, 0, 32'd700);
    // zero tracked coordinate at lift falls back to the start point
    row(CMD_PRESS, 0, 32'd710);
    row(CMD_POS_Y, 3000, 32'd800);
    row(CMD_POS_X, 2000, 32'd810);
    row(CMD_POS_X, 0, 32'd820);
    row(CMD_LIFT, 0, 32'd830);
    row(CMD_ACK, 0, 32'd840);
    foreach (event_table[i])
      send_ev(event_table[i].cmd, event_table[i].coord, event_table[i].t,
              event_table[i].pinned, event_table[i].want);
    drain_status();

    // register settings: reset values, both extremes, mixed and random
    click_set = '{CLICK_DIST_RESET, 12'd0, 12'd4095, 12'($urandom), 12'd5, 12'($urandom)};
    swipe_set = '{SWIPE_DIST_RESET, 12'd0, 12'd4095, 12'($urandom), 12'd1000,
                  12'($urandom_range(0, 300))};
    drag_set  = '{DRAG_MS_RESET, 16'd0, 16'd65535, 16'($urandom), 16'd30,
                  16'($urandom_range(0, 2000))};

    for (ph = 0; ph < NUM_SETTINGS; ph++) begin
      if (ph > 0) begin
        write_reg(CFG_CLICK_DIST, {4'($urandom), click_set[ph]});
        write_reg(CFG_SWIPE_DIST, {4'($urandom), swipe_set[ph]});
        write_reg(CFG_DRAG_MS, drag_set[ph]);
        cfg_write <= 1'b0;
        @(posedge clk);
        settings_run++;
      end
      run_random(PHASE_ITEMS, ph == 2 || ph == 4);
      drain_status();
    end

    repeat (SETTLE) @(posedge clk);
    $display("ran %0d events and %0d status beats over %0d register settings, %0d long holds",
             events_sent, beats_seen, settings_run, holds_done);
    $display("gestures: none %0d click %0d up %0d down %0d left %0d right %0d, drags %0d",
             gesture_tally[0], gesture_tally[1], gesture_tally[2], gesture_tally[3],
             gesture_tally[4], gesture_tally[5], drag_entries);
    if (errors == 0 && status_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d status beats missing", errors, status_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
